// ===== sv/snrs_pkg.sv =====
package snrs_pkg;

   localparam int Q_W       = 64;
   localparam int TOL_W     = 63;
   localparam int LIMIT_W   = 16;
   localparam int STATUS_W  = 2;
   localparam int CSR_IDX_W = 1;
   localparam int DIV_CNT_W = 7;

   localparam logic [TOL_W-1:0]   TOL_RESET   = 63'd4295;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd100;
   localparam logic [DIV_CNT_W-1:0] DIV_LAST  = 7'd95;

   localparam logic signed [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
   localparam logic signed [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

   localparam logic [CSR_IDX_W-1:0] CSR_STEP_TOL   = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ITER_LIMIT = 1'd1;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_EVAL       = 2'd0,
      STATUS_FOUND      = 2'd1,
      STATUS_NO_BRACKET = 2'd2,
      STATUS_LIMIT      = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      PH_IDLE, PH_WAIT_A, PH_WAIT_B, PH_ITER
   } phase_type;

   typedef enum logic [1:0] {
      PROD_HI, PROD_LO, PROD_REACH
   } prod_type;

   typedef enum logic [2:0] {
      ST_READY, ST_LOAD, ST_MUL, ST_EVAL, ST_DIV, ST_NEWTON, ST_BISECT, ST_FINISH
   } state_type;

endpackage

// ===== sv/snrs_req_if.sv =====
interface snrs_req_if;
   import snrs_pkg::*;
   logic                  valid;
   logic                  ready;
   logic                  mode;
   logic signed [Q_W-1:0] bound_a;
   logic signed [Q_W-1:0] bound_b;
   logic signed [Q_W-1:0] f_value;
   logic signed [Q_W-1:0] df_value;

   modport source (output valid, mode, bound_a, bound_b, f_value, df_value, input ready);
   modport sink   (input valid, mode, bound_a, bound_b, f_value, df_value, output ready);
endinterface

// ===== sv/snrs_rsp_if.sv =====
interface snrs_rsp_if;
   import snrs_pkg::*;
   logic                  valid;
   logic                  ready;
   logic signed [Q_W-1:0] query_x;
   logic [STATUS_W-1:0]   status;

   modport source (output valid, query_x, status, input ready);
   modport sink   (input valid, query_x, status, output ready);
endinterface

// ===== sv/safeguarded_newton_root_search.sv =====
// Channel   Dir  Handshake      Payload
// req_if    in   valid/ready    mode, bound_a, bound_b, f_value, df_value
// rsp_if    out  valid/ready    query_x, status
// csr       in   csr_we only    csr_index, csr_wdata
//
// Start requests and end-point results are answered directly from the response register.
// An iterate request below the iteration limit runs the shared 32x32
// multiplier over three 64x64 products, then a bisection or the radix-2
// Newton divider; the divider sets the pace.
// Reset is synchronous, active high; it clears sequencer, phase, response valid, iteration count and configuration.
// Requests are held off while a search step runs or a response is still pending.
module safeguarded_newton_root_search (
   input  logic                            clock,
   input  logic                            reset,
   snrs_req_if.sink                        req_if,
   snrs_rsp_if.source                      rsp_if,
   input  logic                            csr_we,
   input  logic [snrs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [snrs_pkg::Q_W-1:0]        csr_wdata
);
   import snrs_pkg::*;

   function automatic logic signed [Q_W-1:0] sat65(input logic signed [Q_W:0] v);
      if (v[Q_W] != v[Q_W-1]) return v[Q_W] ? Q_MIN : Q_MAX;
      return v[Q_W-1:0];
   endfunction

   // configuration
   logic [TOL_W-1:0]   tol_ff;
   logic [LIMIT_W-1:0] limit_ff;

   // sequencer and search state
   state_type st_ff, st_in;
   phase_type phase_ff, phase_in;
   prod_type  prod_ff, prod_in;
   logic [1:0] part_ff, part_in;
   logic signed [Q_W-1:0] neg_ff, neg_in, pos_ff, pos_in, est_ff, est_in;
   logic signed [Q_W-1:0] last_ff, last_in, prior_ff, prior_in, low_ff, low_in;
   logic [LIMIT_W-1:0] count_ff, count_in;

   // working registers of the shared unit
   logic signed [Q_W-1:0] f_ff, f_in, df_ff, df_in;
   logic [Q_W-1:0]   fmag_ff, fmag_in, dfmag_ff, dfmag_in, opa_ff, opa_in;
   logic             psign_ff, psign_in;
   logic [2*Q_W-1:0] acc_ff, acc_in;
   logic             hi_neg_ff, hi_neg_in, hi_zero_ff, hi_zero_in, bisect_ff, bisect_in;
   logic [Q_W-1:0]   rem_ff, rem_in, q_ff, q_in;
   logic             ovf_ff, ovf_in;
   logic [Q_W+31:0]  num_ff, num_in;
   logic [DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;

   // response register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic signed [Q_W-1:0] rsp_x_ff, rsp_x_in;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;

   logic accept;

   assign req_if.ready   = (st_ff == ST_READY) && (!rsp_valid_ff || rsp_if.ready);
   assign accept         = req_if.valid && req_if.ready;
   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.query_x = rsp_x_ff;
   assign rsp_if.status  = rsp_status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff   <= TOL_RESET;
         limit_ff <= LIMIT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_STEP_TOL:   tol_ff   <= csr_wdata[TOL_W-1:0];
            CSR_ITER_LIMIT: limit_ff <= csr_wdata[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_READY;
         phase_ff     <= PH_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         st_ff        <= st_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;       part_ff <= part_in;
      neg_ff <= neg_in;         pos_ff <= pos_in;       est_ff <= est_in;
      last_ff <= last_in;       prior_ff <= prior_in;   low_ff <= low_in;
      f_ff <= f_in;             df_ff <= df_in;
      fmag_ff <= fmag_in;       dfmag_ff <= dfmag_in;   opa_ff <= opa_in;
      psign_ff <= psign_in;     acc_ff <= acc_in;
      hi_neg_ff <= hi_neg_in;   hi_zero_ff <= hi_zero_in; bisect_ff <= bisect_in;
      rem_ff <= rem_in;         q_ff <= q_in;           ovf_ff <= ovf_in;
      num_ff <= num_in;         div_cnt_ff <= div_cnt_in;
      rsp_x_ff <= rsp_x_in;     rsp_status_ff <= rsp_status_in;
   end

   always_comb begin
      logic signed [Q_W:0]   ab_sum, ab_diff, d, span_abs, step_sum;
      logic [Q_W-1:0]        span_sat, qv, last_mag;
      logic [31:0]           a_part, b_part;
      logic [Q_W-1:0]        pp;
      logic [2*Q_W-1:0]      pp_sh;
      logic signed [2*Q_W:0] sv;
      logic signed [2*Q_W+2:0] tv;
      logic                  t_neg, t_zero;
      logic [Q_W:0]          r65, r_sub;
      logic                  ge;

      st_in = st_ff;  phase_in = phase_ff;  prod_in = prod_ff;  part_in = part_ff;
      neg_in = neg_ff;  pos_in = pos_ff;  est_in = est_ff;
      last_in = last_ff;  prior_in = prior_ff;  low_in = low_ff;  count_in = count_ff;
      f_in = f_ff;  df_in = df_ff;  fmag_in = fmag_ff;  dfmag_in = dfmag_ff;
      opa_in = opa_ff;  psign_in = psign_ff;  acc_in = acc_ff;
      hi_neg_in = hi_neg_ff;  hi_zero_in = hi_zero_ff;  bisect_in = bisect_ff;
      rem_in = rem_ff;  q_in = q_ff;  ovf_in = ovf_ff;  num_in = num_ff;
      div_cnt_in = div_cnt_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      rsp_x_in      = rsp_x_ff;
      rsp_status_in = rsp_status_ff;

      // end-point setup: midpoint and bracket width
      ab_sum   = {neg_ff[Q_W-1], neg_ff} + {pos_ff[Q_W-1], pos_ff};
      ab_diff  = {pos_ff[Q_W-1], pos_ff} - {neg_ff[Q_W-1], neg_ff};
      span_abs = ab_diff[Q_W] ? -ab_diff : ab_diff;
      span_sat = span_abs[Q_W-1] ? Q_MAX : span_abs[Q_W-1:0];

      // signed distance from the estimate to one bracket end
      d = (prod_ff == PROD_HI) ? ({est_ff[Q_W-1], est_ff} - {pos_ff[Q_W-1], pos_ff})
                               : ({est_ff[Q_W-1], est_ff} - {neg_ff[Q_W-1], neg_ff});

      // one partial product of the shared multiplier
      a_part = part_ff[1] ? opa_ff[Q_W-1:32] : opa_ff[31:0];
      b_part = part_ff[0] ? dfmag_ff[Q_W-1:32] : dfmag_ff[31:0];
      pp     = a_part * b_part;
      unique case (part_ff)
         2'd0:       pp_sh = {64'b0, pp};
         2'd1, 2'd2: pp_sh = {32'b0, pp, 32'b0};
         default:    pp_sh = {pp, 64'b0};
      endcase

      // sign of (x - end) * df - f, all in Q64.64
      sv     = psign_ff ? -$signed({1'b0, acc_ff}) : $signed({1'b0, acc_ff});
      tv     = {{2{sv[2*Q_W]}}, sv} - {{35{f_ff[Q_W-1]}}, f_ff, 32'b0};
      t_neg  = tv[2*Q_W+2];
      t_zero = (tv == '0);

      // restoring divide step
      r65   = {rem_ff, num_ff[Q_W+31]};
      r_sub = r65 - {1'b0, dfmag_ff};
      ge    = (r65 >= {1'b0, dfmag_ff});

      qv       = (ovf_ff || q_ff[Q_W-1]) ? Q_MAX : q_ff;
      step_sum = bisect_ff ? ({neg_ff[Q_W-1], neg_ff} + {last_ff[Q_W-1], last_ff})
                           : ({est_ff[Q_W-1], est_ff} - {last_ff[Q_W-1], last_ff});
      last_mag = last_ff[Q_W-1] ? -last_ff : last_ff;

      unique case (st_ff)
         ST_READY: begin
            if (accept) begin
               if (!req_if.mode) begin
                  // start request aborts any search and asks for f at bound_a
                  neg_in = req_if.bound_a;
                  pos_in = req_if.bound_b;
                  phase_in = PH_WAIT_A;
                  rsp_valid_in = 1'b1;
                  rsp_x_in = req_if.bound_a;
                  rsp_status_in = STATUS_EVAL;
               end else begin
                  unique case (phase_ff)
                     PH_IDLE: ;  // stray result: drop
                     PH_WAIT_A: begin
                        rsp_valid_in = 1'b1;
                        if (req_if.f_value == '0) begin
                           phase_in = PH_IDLE;
                           rsp_x_in = neg_ff;
                           rsp_status_in = STATUS_FOUND;
                        end else begin
                           low_in = req_if.f_value;
                           phase_in = PH_WAIT_B;
                           rsp_x_in = pos_ff;
                           rsp_status_in = STATUS_EVAL;
                        end
                     end
                     PH_WAIT_B: begin
                        rsp_valid_in = 1'b1;
                        if (req_if.f_value == '0) begin
                           phase_in = PH_IDLE;
                           rsp_x_in = pos_ff;
                           rsp_status_in = STATUS_FOUND;
                        end else if ((!low_ff[Q_W-1] && low_ff != '0) ==
                                     (!req_if.f_value[Q_W-1])) begin
                           phase_in = PH_IDLE;
                           rsp_x_in = '0;
                           rsp_status_in = STATUS_NO_BRACKET;
                        end else begin
                           if (!low_ff[Q_W-1]) begin
                              neg_in = pos_ff;
                              pos_in = neg_ff;
                           end
                           est_in = ab_sum[Q_W:1];
                           prior_in = span_sat;
                           last_in = span_sat;
                           count_in = '0;
                           phase_in = PH_ITER;
                           rsp_x_in = ab_sum[Q_W:1];
                           rsp_status_in = STATUS_EVAL;
                        end
                     end
                     default: begin
                        // move the bracket end on the side of f, except after the midpoint
                        if (count_ff != '0) begin
                           if (req_if.f_value[Q_W-1]) neg_in = est_ff;
                           else pos_in = est_ff;
                        end
                        if (count_ff >= limit_ff) begin
                           phase_in = PH_IDLE;
                           rsp_valid_in = 1'b1;
                           rsp_x_in = est_ff;
                           rsp_status_in = STATUS_LIMIT;
                        end else begin
                           f_in = req_if.f_value;
                           df_in = req_if.df_value;
                           fmag_in = req_if.f_value[Q_W-1] ? -req_if.f_value : req_if.f_value;
                           dfmag_in = req_if.df_value[Q_W-1] ? -req_if.df_value
                                                             : req_if.df_value;
                           prod_in = PROD_HI;
                           st_in = ST_LOAD;
                        end
                     end
                  endcase
               end
            end
         end
         ST_LOAD: begin
            if (prod_ff == PROD_REACH) begin
               opa_in = prior_ff[Q_W-1] ? -prior_ff : prior_ff;
            end else begin
               opa_in = d[Q_W] ? -d[Q_W-1:0] : d[Q_W-1:0];
            end
            psign_in = d[Q_W] ^ df_ff[Q_W-1];
            acc_in = '0;
            part_in = '0;
            st_in = ST_MUL;
         end
         ST_MUL: begin
            acc_in = acc_ff + pp_sh;
            part_in = part_ff + 2'd1;
            if (part_ff == 2'd3) st_in = ST_EVAL;
         end
         ST_EVAL: begin
            unique case (prod_ff)
               PROD_HI: begin
                  hi_neg_in = t_neg;
                  hi_zero_in = t_zero;
                  prod_in = PROD_LO;
                  st_in = ST_LOAD;
               end
               PROD_LO: begin
                  // Newton point not strictly inside the bracket, or flat slope
                  bisect_in = hi_zero_ff || t_zero || (hi_neg_ff == t_neg) || (dfmag_ff == '0);
                  prod_in = PROD_REACH;
                  st_in = ST_LOAD;
               end
               default: begin
                  prior_in = last_ff;
                  if (bisect_ff || ({31'b0, fmag_ff, 33'b0} > acc_ff)) begin
                     bisect_in = 1'b1;
                     st_in = ST_BISECT;
                  end else begin
                     rem_in = '0;
                     q_in = '0;
                     ovf_in = 1'b0;
                     num_in = {fmag_ff, 32'b0};
                     div_cnt_in = DIV_LAST;
                     st_in = ST_DIV;
                  end
               end
            endcase
         end
         ST_DIV: begin
            ovf_in = ovf_ff | q_ff[Q_W-1];
            q_in = {q_ff[Q_W-2:0], ge};
            rem_in = ge ? r_sub[Q_W-1:0] : r65[Q_W-1:0];
            num_in = num_ff << 1;
            div_cnt_in = div_cnt_ff - 1'b1;
            if (div_cnt_ff == '0) st_in = ST_NEWTON;
         end
         ST_NEWTON: begin
            last_in = (f_ff[Q_W-1] != df_ff[Q_W-1]) ? -qv : qv;
            st_in = ST_FINISH;
         end
         ST_BISECT: begin
            last_in = ab_diff[Q_W:1];
            st_in = ST_FINISH;
         end
         default: begin
            est_in = sat65(step_sum);
            count_in = count_ff + 1'b1;
            rsp_valid_in = 1'b1;
            rsp_x_in = sat65(step_sum);
            if ({1'b0, tol_ff} > last_mag) begin
               phase_in = PH_IDLE;
               rsp_status_in = STATUS_FOUND;
            end else begin
               rsp_status_in = STATUS_EVAL;
            end
            st_in = ST_READY;
         end
      endcase
   end

`ifndef SYNTH
   a_div_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_DIV) |-> (dfmag_ff != '0))
      else $error("divider running with zero derivative");

   a_div_to_newton: assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_DIV && div_cnt_ff == '0) |=> (st_ff == ST_NEWTON))
      else $error("divider did not finish after last step");

   a_iter_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      (accept && req_if.mode && phase_ff == PH_ITER && count_ff < limit_ff)
      |=> (!rsp_valid_ff && st_ff == ST_LOAD))
      else $error("iterate request produced an early response");

   a_busy_not_idle: assert property (@(posedge clock) disable iff (reset)
      (st_ff != ST_READY) |-> (phase_ff == PH_ITER))
      else $error("step running outside iterate phase");
`endif

endmodule
